[hw/rtl/lfs_pkg.sv]
// Shared types and constants for the Lambert fragment shading pipeline.
// No dependencies; used by lfs_isqrt, lfs_div and the top level.
`timescale 1ns / 1ps
package lfs_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_INTENSITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALBEDO = 3'd4;

  localparam logic [47:0] LIGHT_DIR_RST = 48'd3221225472;
  localparam logic [47:0] LIGHT_COLOR_RST = 48'd17592454483968;
  localparam logic [15:0] LIGHT_INTENSITY_RST = 16'd4096;
  localparam logic [47:0] AMBIENT_RST = 48'd3517631890227;
  localparam logic [47:0] ALBEDO_RST = 48'd17592454483968;

  localparam int unsigned DOT_W = 34;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned RAD_W = 64;
  localparam int unsigned F_W = 15;
  localparam logic [F_W-1:0] F_ONE = 15'd16384;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    texel_t tex;
  } sq_side_t;

endpackage

[hw/rtl/lfs_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on lfs_pkg.
`timescale 1ns / 1ps
module lfs_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [lfs_pkg::RAD_W-1:0]       in_rad,
  input  lfs_pkg::sq_side_t               in_side,
  output logic                            out_valid,
  output logic [lfs_pkg::ROOT_W-1:0]      out_root,
  output lfs_pkg::sq_side_t               out_side
);
  import lfs_pkg::*;

  localparam int unsigned N = ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic              vld  [0:N];
  logic [REM_W-1:0]  rem  [0:N];
  logic [ROOT_W-1:0] root [0:N];
  logic [RAD_W-1:0]  rad  [0:N];
  sq_side_t          side [0:N];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign root[0] = '0;
  assign rad[0] = in_rad;
  assign side[0] = in_side;

  for (genvar i = 1; i <= N; i++) begin : g_step
    logic [REM_W+1:0] trial_in;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    always_comb begin
      trial_in = {rem[i-1], rad[i-1][RAD_W-1 -: 2]};
      trial = {2'b00, root[i-1], 2'b01};
      ge = trial_in >= trial;
      diff = trial_in - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (ce) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i] <= ge ? diff[REM_W-1:0] : trial_in[REM_W-1:0];
        root[i] <= {root[i-1][ROOT_W-2:0], ge};
        rad[i] <= {rad[i-1][RAD_W-3:0], 2'b00};
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root = root[N];
  assign out_side = side[N];

endmodule

[hw/rtl/lfs_div.sv]
// Pipelined restoring divider for the diffuse factor, one quotient bit a stage,
// with zero and negative-dot detection and the cap at 1.0. Depends on lfs_pkg.
`timescale 1ns / 1ps
module lfs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic signed [lfs_pkg::DOT_W-1:0] in_dot,
  input  logic [lfs_pkg::ROOT_W-1:0]    in_den,
  input  lfs_pkg::texel_t               in_tex,
  output logic                          out_valid,
  output logic [lfs_pkg::F_W-1:0]       out_f,
  output lfs_pkg::texel_t               out_tex
);
  import lfs_pkg::*;

  localparam int unsigned N = F_W;
  localparam int unsigned R_W = ROOT_W + 2;

  logic              vld  [0:N];
  logic              zero [0:N];
  logic [R_W-1:0]    r    [0:N];
  logic [ROOT_W-1:0] den  [0:N];
  logic [F_W-1:0]    q    [0:N];
  texel_t            tex  [0:N];

  assign vld[0] = in_valid;
  assign zero[0] = in_dot[DOT_W-1] || (in_dot == '0) || (in_den == '0);
  assign r[0] = {1'b0, in_dot[DOT_W-2:0]};
  assign den[0] = in_den;
  assign q[0] = '0;
  assign tex[0] = in_tex;

  for (genvar i = 1; i <= N; i++) begin : g_step
    logic [R_W-1:0] den_x;
    logic [R_W-1:0] diff;
    logic           ge;

    always_comb begin
      den_x = {2'b00, den[i-1]};
      ge = r[i-1] >= den_x;
      diff = r[i-1] - den_x;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (ce) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        r[i] <= ge ? {diff[R_W-2:0], 1'b0} : {r[i-1][R_W-2:0], 1'b0};
        q[i] <= {q[i-1][F_W-2:0], ge};
        den[i] <= den[i-1];
        zero[i] <= zero[i-1];
        tex[i] <= tex[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (zero[N]) begin
        out_f <= '0;
      end else if (q[N] > F_ONE) begin
        out_f <= F_ONE;
      end else begin
        out_f <= q[N];
      end
      out_tex <= tex[N];
    end
  end

endmodule

[hw/rtl/lambert_fragment_shading_top.sv]
// Lambert diffuse plus ambient fragment shader, fully pipelined.
// Stages: 3 setup stages, 32 square root stages, 16 divider stages,
// 5 color stages. Throughput one fragment per cycle unless stalled; a single
// pipeline-wide enable stalls every stage when the output transfer is held.
// Synchronous active-high reset clears the valid bits and loads the register
// defaults. Depends on lfs_pkg, lfs_isqrt and lfs_div.
`timescale 1ns / 1ps
module lambert_fragment_shading_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // normal_x, normal_y, normal_z, texel_red, texel_green, texel_blue, texel_alpha
  input  logic [79:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // shaded_red, shaded_green, shaded_blue, shaded_alpha
  output logic [31:0]                       m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lfs_pkg::*;

  logic [47:0] light_dir;
  logic [47:0] light_color;
  logic [15:0] light_intensity;
  logic [47:0] ambient;
  logic [47:0] albedo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_dir <= LIGHT_DIR_RST;
      light_color <= LIGHT_COLOR_RST;
      light_intensity <= LIGHT_INTENSITY_RST;
      ambient <= AMBIENT_RST;
      albedo <= ALBEDO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIGHT_DIR: light_dir <= cfg_data;
        REG_LIGHT_COLOR: light_color <= cfg_data;
        REG_LIGHT_INTENSITY: light_intensity <= cfg_data[15:0];
        REG_AMBIENT: ambient <= cfg_data;
        REG_ALBEDO: albedo <= cfg_data;
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // stage 1: products
  logic signed [16:0] n_in [3];
  logic signed [16:0] l_in [3];
  logic signed [33:0] p_nl [3];
  logic signed [33:0] p_nn [3];
  logic signed [33:0] p_ll [3];
  texel_t tex_in;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_in[k] = $signed({s_axis_tdata[16*k+15], s_axis_tdata[16*k +: 16]});
      l_in[k] = -$signed({light_dir[16*k+15], light_dir[16*k +: 16]});
      p_nl[k] = n_in[k] * l_in[k];
      p_nn[k] = n_in[k] * n_in[k];
      p_ll[k] = l_in[k] * l_in[k];
    end
    tex_in.red = s_axis_tdata[55:48];
    tex_in.green = s_axis_tdata[63:56];
    tex_in.blue = s_axis_tdata[71:64];
    tex_in.alpha = s_axis_tdata[79:72];
  end

  logic               v1;
  logic signed [33:0] nl1 [3];
  logic [30:0]        nn1 [3];
  logic [30:0]        ll1 [3];
  texel_t             tex1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        nl1[k] <= p_nl[k];
        nn1[k] <= p_nn[k][30:0];
        ll1[k] <= p_ll[k][30:0];
      end
      tex1 <= tex_in;
    end
  end

  // stage 2: sums
  logic                    v2;
  logic signed [DOT_W-1:0] dot2;
  logic [31:0]             nn2;
  logic [31:0]             ll2;
  texel_t                  tex2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dot2 <= nl1[0] + nl1[1] + nl1[2];
      nn2 <= {1'b0, nn1[0]} + {1'b0, nn1[1]} + {1'b0, nn1[2]};
      ll2 <= {1'b0, ll1[0]} + {1'b0, ll1[1]} + {1'b0, ll1[2]};
      tex2 <= tex1;
    end
  end

  // stage 3: product of squared lengths
  logic             v3;
  logic [RAD_W-1:0] rad3;
  sq_side_t         side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rad3 <= nn2 * ll2;
      side3.dot <= dot2;
      side3.tex <= tex2;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  lfs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v3),
    .in_rad    (rad3),
    .in_side   (side3),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic           dv_valid;
  logic [F_W-1:0] dv_f;
  texel_t         dv_tex;

  lfs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sq_valid),
    .in_dot    (sq_side.dot),
    .in_den    (sq_root),
    .in_tex    (sq_side.tex),
    .out_valid (dv_valid),
    .out_f     (dv_f),
    .out_tex   (dv_tex)
  );

  // color stages
  logic        va, vb, vc, vd;
  logic [30:0] cf_a [3];
  logic [21:0] t_b  [3];
  logic [29:0] tt_c [3];
  logic [45:0] p_d  [3];
  texel_t      tex_a, tex_b, tex_c, tex_d;
  logic [46:0] dif_full [3];
  logic [7:0]  tex_ch   [3];
  logic [46:0] rnd      [3];
  logic [7:0]  shade    [3];

  always_comb begin
    tex_ch[0] = tex_b.red;
    tex_ch[1] = tex_b.green;
    tex_ch[2] = tex_b.blue;
    for (int k = 0; k < 3; k++) begin
      dif_full[k] = cf_a[k] * light_intensity;
      rnd[k] = {1'b0, p_d[k]} + 47'd8388608;
      shade[k] = (rnd[k][46:24] > 23'd255) ? 8'd255 : rnd[k][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      va <= dv_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      m_axis_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        cf_a[k] <= light_color[16*k +: 16] * dv_f;
        t_b[k] <= {6'd0, ambient[16*k +: 16]} + {1'b0, dif_full[k][46:26]};
        tt_c[k] <= t_b[k] * tex_ch[k];
        p_d[k] <= tt_c[k] * albedo[16*k +: 16];
      end
      tex_a <= dv_tex;
      tex_b <= tex_a;
      tex_c <= tex_b;
      tex_d <= tex_c;
      m_axis_tdata <= {tex_d.alpha, shade[2], shade[1], shade[0]};
    end
  end

  // cauchy-schwarz: a positive dot never exceeds the floored root
  a_dot_le_root: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !sq_side.dot[DOT_W-1]) |-> (sq_side.dot[DOT_W-2:0] <= {1'b0, sq_root}))
    else $error("dot exceeds length product");

  a_f_capped: assert property (@(posedge clk) disable iff (rst)
    dv_valid |-> (dv_f <= F_ONE))
    else $error("diffuse factor above one");

  a_rst_clears: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !v1 && !dv_valid))
    else $error("valid set after reset");

endmodule
